// ----- hw/rtl/itr_pkg.sv -----
// shared constants, types and numeral tables for the integer to roman converter
package itr_pkg;

    localparam int DIGITS   = 6;
    localparam int VALUE_W  = 20;
    localparam int LETTER_W = 7;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = $clog2(VALUE_W);
    localparam int PLACE_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int LIDX_W   = 4;

    // letter roles inside one decimal place
    localparam logic [1:0] KIND_ONE  = 2'd0;
    localparam logic [1:0] KIND_FIVE = 2'd1;
    localparam logic [1:0] KIND_TEN  = 2'd2;

    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit;
    } itr_cmd_t;

    typedef struct packed {
        logic last_shift;
        logic all_zero;
        logic digit_zero;
        logic out_free;
        logic final_letter;
    } itr_status_t;

    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

    // number of letters a digit spells
    function automatic logic [2:0] pat_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] pat_kind(input logic [3:0] d, input logic [1:0] k);
        logic [1:0] r;
        if (d == 4'd9)
            r = (k == 2'd0) ? KIND_ONE : KIND_TEN;
        else if (d == 4'd4)
            r = (k == 2'd0) ? KIND_ONE : KIND_FIVE;
        else if (d >= 4'd5)
            r = (k == 2'd0) ? KIND_FIVE : KIND_ONE;
        else
            r = KIND_ONE;
        return r;
    endfunction

    // lower-case letters stand for the overlined symbols
    function automatic logic [LETTER_W-1:0] letter_of(input logic [LIDX_W-1:0] idx);
        logic [LETTER_W-1:0] c;
        case (idx)
            4'd0:    c = 7'h49; // I
            4'd1:    c = 7'h56; // V
            4'd2:    c = 7'h58; // X
            4'd3:    c = 7'h4C; // L
            4'd4:    c = 7'h43; // C
            4'd5:    c = 7'h44; // D
            4'd6:    c = 7'h4D; // M
            4'd7:    c = 7'h76; // v
            4'd8:    c = 7'h78; // x
            4'd9:    c = 7'h6C; // l
            4'd10:   c = 7'h63; // c
            4'd11:   c = 7'h64; // d
            4'd12:   c = 7'h6D; // m
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/itr_in_if.sv -----
// input channel: one integer per request
interface itr_in_if import itr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/itr_out_if.sv -----
// output channel: one numeral letter per request
interface itr_out_if import itr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;

    modport source (output valid, output letter, output last_letter, input ready);
    modport sink   (input valid, input letter, input last_letter, output ready);
endinterface

// ----- hw/rtl/itr_ctrl.sv -----
// controller state machine: convert, then walk the places and emit letters
module itr_ctrl import itr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  itr_status_t status,
    output itr_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.last_shift)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.all_zero)
                    state_next = S_IDLE;
                else if (status.digit_zero)
                    cmd.skip = 1'b1;
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.final_letter)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/itr_datapath.sv -----
// datapath: shift-add-3 binary to bcd, place/step walk and output register
module itr_datapath import itr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  itr_cmd_t           cmd,
    output itr_status_t        status,
    itr_out_if.source          out_ch
);

    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [VALUE_W-1:0]  sh_reg;
    logic [VALUE_W-1:0]  sh_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [PLACE_W-1:0]  place_reg;
    logic [PLACE_W-1:0]  place_next;
    logic [1:0]          step_reg;
    logic [1:0]          step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LETTER_W-1:0] letter_reg;
    logic [LETTER_W-1:0] letter_next;
    logic                last_reg;
    logic                last_next;

    logic [BCD_W-1:0]    adj;
    logic [3:0]          digit;
    logic [2:0]          len;
    logic                digit_last;
    logic                lower_nz;
    logic [LIDX_W-1:0]   lidx;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
            adj[4*i +: 4] = add3(bcd_reg[4*i +: 4]);
    end

    assign digit      = bcd_reg[4*place_reg +: 4];
    assign len        = pat_len(digit);
    assign digit_last = ({1'b0, step_reg} + 3'd1) == len;
    assign lidx       = LIDX_W'({place_reg, 1'b0}) + LIDX_W'(pat_kind(digit, step_reg));

    always_comb
    begin
        lower_nz = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if ((PLACE_W'(i) < place_reg) && (bcd_reg[4*i +: 4] != 4'd0))
                lower_nz = 1'b1;
        end
    end

    always_comb
    begin
        status.last_shift   = cnt_reg == CNT_W'(VALUE_W - 1);
        status.all_zero     = bcd_reg == '0;
        status.digit_zero   = digit == 4'd0;
        status.out_free     = !out_valid_reg || out_ch.ready;
        status.final_letter = digit_last && !lower_nz;
    end

    always_comb
    begin
        bcd_next       = bcd_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        place_next     = place_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        letter_next    = letter_reg;
        last_next      = last_reg;
        if (cmd.load)
        begin
            bcd_next   = '0;
            sh_next    = value;
            cnt_next   = '0;
            place_next = PLACE_W'(DIGITS - 1);
            step_next  = 2'd0;
        end
        if (cmd.shift)
        begin
            // carry out of the top digit drops the places above DIGITS
            bcd_next = {adj[BCD_W-2:0], sh_reg[VALUE_W-1]};
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.skip)
            place_next = place_reg - PLACE_W'(1);
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            letter_next    = letter_of(lidx);
            last_next      = status.final_letter;
            if (digit_last)
            begin
                step_next = 2'd0;
                if (!status.final_letter)
                    place_next = place_reg - PLACE_W'(1);
            end
            else
                step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        bcd_reg    <= bcd_next;
        sh_reg     <= sh_next;
        cnt_reg    <= cnt_next;
        place_reg  <= place_next;
        step_reg   <= step_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.letter      = letter_reg;
    assign out_ch.last_letter = last_reg;

endmodule

// ----- hw/rtl/integer_to_roman_numeral_top.sv -----
// top level of the integer to roman numeral converter
//
//  channel  dir  payload              request meaning
//  in_ch    in   value[19:0]          one integer to spell
//  out_ch   out  letter[6:0], last    one ascii numeral letter, last on final one
//
//  a request is loaded, converted by shift-add-3, one bit per cycle, then the places are
//  walked from the top, emitting each letter and skipping each zero place before the final letter.
//  a zero value emits nothing.
//  rst_n is asynchronous and active low; it clears the state machine and output valid.
//  a stalled out_ch holds the letter register and pauses the letter walk at its next letter.
//  the next request is taken while the final letter still waits in the output register.
module integer_to_roman_numeral_top import itr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    itr_in_if.sink    in_ch,
    itr_out_if.source out_ch
);

    itr_cmd_t    cmd;
    itr_status_t status;
    logic        ready_w;

    assign in_ch.ready = ready_w;

    itr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready_w),
        .status   (status),
        .cmd      (cmd)
    );

    itr_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (in_ch.value),
        .cmd    (cmd),
        .status (status),
        .out_ch (out_ch)
    );

    // a letter is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("letter loaded over a pending letter");

    // an accepted request starts the conversion next cycle
    a_load_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && ready_w) |=> (cmd.shift && !ready_w))
        else $error("conversion did not start after accept");

    // after the final letter the block is ready again
    a_final_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.final_letter) |=> ready_w)
        else $error("not ready after final letter");

endmodule

// ----- tb/tb_integer_to_roman_numeral_top.sv -----
// self-checking testbench for the integer to roman numeral converter
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral_top;
    import itr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 31;
    localparam int HOLD_ITEMS = 20;
    localparam int REPORT_MAX = 10;
    // one, five and ten of each place, units first
    localparam logic [8*13-1:0] GLYPH_CODES = "IVXLCDMvxlcdm";

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } numeral_letter_t;

    logic clk = 1'b0;
    logic rst_n;

    itr_in_if  in_ch ();
    itr_out_if out_ch ();

    integer_to_roman_numeral_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [VALUE_W-1:0] value_pending[$];
    numeral_letter_t    numeral_expected[$];
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        hold_left;
    logic               hold_arm = 1'b0;
    logic               in_taken;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;

    always #5 clk = ~clk;

    // spell one value and queue its letters in reading order
    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        int unsigned     rest;
        int unsigned     digit;
        int unsigned     one;
        int unsigned     k;
        int              p;
        int unsigned     glyph_idx[$];
        numeral_letter_t item;
        rest = v % (10 ** DIGITS);
        for (p = DIGITS - 1; p >= 0; p--)
        begin
            digit = (rest / (10 ** p)) % 10;
            one = 2 * p;
            if (digit == 9)
            begin
                glyph_idx.push_back(one);
                glyph_idx.push_back(one + 2);
            end
            else if (digit == 4)
            begin
                glyph_idx.push_back(one);
                glyph_idx.push_back(one + 1);
            end
            else
            begin
                if (digit >= 5)
                begin
                    glyph_idx.push_back(one + 1);
                    digit = digit - 5;
                end
                for (k = 0; k < digit; k++)
                    glyph_idx.push_back(one);
            end
        end
        foreach (glyph_idx[i])
        begin
            item.letter = GLYPH_CODES[8 * (12 - glyph_idx[i]) +: LETTER_W];
            item.last = (i == glyph_idx.size() - 1);
            numeral_expected.push_back(item);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned pick;
        int unsigned d;
        int unsigned acc;
        int          p;
        pick = $urandom_range(99);
        acc = 0;
        if (pick < 35)
            acc = $urandom_range(999999);
        else if (pick < 50)
            acc = $urandom_range(2 ** VALUE_W - 1);
        else if (pick < 60)
            acc = $urandom_range(60);
        else
        begin
            for (p = 0; p < DIGITS; p++)
            begin
                if (pick < 80)
                    d = ($urandom_range(3) == 0) ? 0 : $urandom_range(9);
                else
                    // lean toward long numerals
                    d = $urandom_range(1) ? 8 : $urandom_range(9);
                acc = acc + d * (10 ** p);
            end
        end
        return VALUE_W'(acc);
    endfunction

    task automatic wait_all_spelled();
        @(negedge clk);
        while (value_pending.size() != 0 || in_ch.valid || numeral_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic feed_values(input int unsigned send_pct, input int unsigned recv_pct,
                               input int count);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            value_pending.push_back(random_value());
        wait_all_spelled();
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            if (value_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.value <= value_pending.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        numeral_letter_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("integer_to_roman_numeral_top regression: fail");
            $finish;
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (numeral_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected letter %h last %b", out_ch.letter, out_ch.last_letter);
            end
            else
            begin
                want = numeral_expected.pop_front();
                if (out_ch.letter !== want.letter || out_ch.last_letter !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("letter mismatch: expected %h last %b, got %h last %b",
                                 want.letter, want.last, out_ch.letter, out_ch.last_letter);
                end
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_numeral(in_ch.value);
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed values: zero, every subtractive form, place edges, dropped digits
        @(posedge clk);
        value_pending = '{0, 1, 4, 5, 9, 14, 40, 49, 90, 99, 400, 444, 999, 1000, 3999,
                          4000, 9999, 40000, 90909, 444444, 500000, 888888, 999999,
                          1000000, 1000001, 2 ** VALUE_W - 1};
        wait_all_spelled();

        feed_values(0, 0, ITEMS_PER_PHASE);
        feed_values(78, 0, ITEMS_PER_PHASE);
        feed_values(0, 78, ITEMS_PER_PHASE);
        feed_values(27, 27, ITEMS_PER_PHASE);

        // receiver holds off while requests keep coming so the input backs up
        @(negedge clk);
        hold_arm = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
        feed_values(0, 0, HOLD_ITEMS);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && numeral_expected.size() == 0)
            $display("integer_to_roman_numeral_top regression: pass");
        else
            $display("integer_to_roman_numeral_top regression: fail");
        $finish;
    end

endmodule
